[rtl/tnc_pkg.sv]
// Package: shared constants, codes and types of the tag nesting checker.
package tnc_pkg;

  localparam int MAX_NAME_LEN = 20;
  localparam int STACK_DEPTH  = 16;

  localparam int NPOS_W  = $clog2(MAX_NAME_LEN + 1);
  localparam int IDX_W   = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  typedef enum logic [2:0] {
    EV_MARK  = 3'd0,
    EV_TEXT  = 3'd1,
    EV_NAME  = 3'd2,
    EV_OPEN  = 3'd3,
    EV_CLOSE = 3'd4,
    EV_ERR   = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_CLOSE_NONE = 3'd1,
    ERR_MISMATCH   = 3'd2,
    ERR_UNCLOSED   = 3'd3,
    ERR_NAME_LONG  = 3'd4,
    ERR_STACK_FULL = 3'd5,
    ERR_END_IN_TAG = 3'd6
  } err_t;

  typedef logic [MAX_NAME_LEN-1:0][7:0] name_t;

  typedef struct packed {
    name_t             name;
    logic [NPOS_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

[rtl/tnc_if.sv]
// Interfaces: input character channel and result channel.
interface tnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_of_document;

  modport source (output valid, char_in, last_of_document, input ready);
  modport sink   (input valid, char_in, last_of_document, output ready);
endinterface

interface tnc_out_if import tnc_pkg::*;;
  logic       valid;
  logic       ready;
  event_t     event_res;
  logic [4:0] depth;
  logic [7:0] char_out;
  logic       run_start;
  err_t       error_code;
  logic       document_done;

  modport source (output valid, event_res, depth, char_out, run_start, error_code,
                  document_done, input ready);
  modport sink   (input valid, event_res, depth, char_out, run_start, error_code,
                  document_done, output ready);
endinterface

[rtl/tnc_cell.sv]
// Stack cell: holds one name entry, shifts down on push and up on pop.
module tnc_cell import tnc_pkg::*; (
  input  logic     clk,
  input  stk_ctl_t ctl,
  input  entry_t   upper,
  input  entry_t   lower,
  output entry_t   entry
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entry_r <= upper;
    end else if (ctl.pop) begin
      entry_r <= lower;
    end
  end

  assign entry = entry_r;

endmodule

[rtl/tnc_core.sv]
// Top level: tag nesting checker core with a shifting stack of name cells.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------------
//   in_chan | in  | valid/ready       | char_in, last_of_document
//   out_chan| out | valid/ready       | event_res, depth, char_out, run_start,
//           |     |                   | error_code, document_done
//
// One character per cycle while the output is not stalled: the result of an item is
// loaded into the output register at the edge that accepts it and is offered from the
// next cycle on; the stack top always sits in cell 0, so compare and push/pop use cell 0.
// Synchronous active-low reset: text mode, empty stack; name cells are not reset.
// A stalled result holds the output register; take a new item only when that
// register is empty or drains in the same cycle.
module tag_nesting_checker_core import tnc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tnc_in_if.sink    in_chan,
  tnc_out_if.source out_chan
);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_LT   = 2'd1,
    MODE_NAME = 2'd2
  } mode_t;

  // Parser state
  mode_t              mode_r, mode_nxt;
  logic               closing_r, closing_nxt;
  logic [NPOS_W-1:0]  npos_r, npos_nxt;
  logic               mism_r, mism_nxt;
  logic               err_lat_r, err_lat_nxt;
  logic               run_act_r, run_act_nxt;
  logic [DEPTH_W-1:0] top_r, top_nxt;

  // Staging buffer for the opening name being collected
  name_t              stage_r;
  logic               stage_we;

  // Output register
  logic               out_valid_r;
  event_t             ev_r, ev_nxt;
  logic [4:0]         dep_r, dep_nxt;
  logic [7:0]         cout_r, cout_nxt;
  logic               run_r, run_nxt;
  err_t               err_r, err_nxt;
  logic               done_r;

  logic               in_fire;
  logic               push, pop;
  stk_ctl_t           ctl;
  entry_t             cell_q [STACK_DEPTH];
  entry_t             push_entry;
  logic [7:0]         c;
  logic               last;
  logic [IDX_W-1:0]   pos_idx;

  assign c       = in_chan.char_in;
  assign last    = in_chan.last_of_document;
  assign pos_idx = npos_r[IDX_W-1:0];

  // Take an item whenever the output register can be refilled this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Row of stack cells; cell 0 is the stack top
  assign push_entry = '{name: stage_r, len: npos_r};
  assign ctl        = '{push: push && in_fire, pop: pop && in_fire};

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up_d, lo_d;
    if (i == 0) begin : g_first
      assign up_d = push_entry;
    end else begin : g_mid_up
      assign up_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign lo_d = '0;
    end else begin : g_mid_lo
      assign lo_d = cell_q[i+1];
    end
    tnc_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .upper (up_d),
      .lower (lo_d),
      .entry (cell_q[i])
    );
  end

  // Per-character parse step
  always_comb begin
    mode_nxt    = mode_r;
    closing_nxt = closing_r;
    npos_nxt    = npos_r;
    mism_nxt    = mism_r;
    err_lat_nxt = err_lat_r;
    run_act_nxt = run_act_r;
    top_nxt     = top_r;
    stage_we    = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    ev_nxt      = EV_MARK;
    dep_nxt     = '0;
    cout_nxt    = '0;
    run_nxt     = 1'b0;
    err_nxt     = ERR_NONE;

    if (!err_lat_r) begin
      dep_nxt = 5'(top_r);
      if (mode_r == MODE_TEXT) begin
        if (c == CHAR_LT) begin
          // open a tag: clear the per-tag state
          mode_nxt    = MODE_LT;
          closing_nxt = 1'b0;
          npos_nxt    = '0;
          mism_nxt    = 1'b0;
          run_act_nxt = 1'b0;
        end else begin
          ev_nxt      = EV_TEXT;
          cout_nxt    = c;
          run_nxt     = !run_act_r;
          run_act_nxt = 1'b1;
        end
      end else if (mode_r == MODE_LT && c == CHAR_SLASH) begin
        closing_nxt = 1'b1;
        mode_nxt    = MODE_NAME;
      end else if (c == CHAR_GT) begin
        if (closing_r) begin
          if (top_r == '0) begin
            ev_nxt  = EV_ERR;
            err_nxt = ERR_CLOSE_NONE;
          end else if (mism_r || npos_r != cell_q[0].len) begin
            ev_nxt  = EV_ERR;
            err_nxt = ERR_MISMATCH;
          end else begin
            // pop: matched close tag
            pop         = 1'b1;
            top_nxt     = top_r - 1'b1;
            dep_nxt     = 5'(top_nxt);
            ev_nxt      = EV_CLOSE;
            mode_nxt    = MODE_TEXT;
            run_act_nxt = 1'b0;
          end
        end else begin
          if (top_r == DEPTH_W'(STACK_DEPTH)) begin
            ev_nxt  = EV_ERR;
            err_nxt = ERR_STACK_FULL;
          end else begin
            // push: the staged name becomes the new top
            push        = 1'b1;
            top_nxt     = top_r + 1'b1;
            ev_nxt      = EV_OPEN;
            mode_nxt    = MODE_TEXT;
            run_act_nxt = 1'b0;
          end
        end
      end else begin
        if (npos_r >= NPOS_W'(MAX_NAME_LEN)) begin
          ev_nxt  = EV_ERR;
          err_nxt = ERR_NAME_LONG;
        end else begin
          if (closing_r) begin
            // compare against the top entry one character at a time
            if (top_r == '0) begin
              mism_nxt = 1'b1;
              dep_nxt  = '0;
            end else begin
              if (npos_r >= cell_q[0].len || cell_q[0].name[pos_idx] != c) begin
                mism_nxt = 1'b1;
              end
              dep_nxt = 5'(top_r - 1'b1);
            end
          end else begin
            stage_we = 1'b1;
          end
          run_nxt  = (npos_r == '0);
          npos_nxt = npos_r + 1'b1;
          mode_nxt = MODE_NAME;
          ev_nxt   = EV_NAME;
          cout_nxt = c;
        end
      end

      // end-of-document checks on the updated state
      if (ev_nxt != EV_ERR && last) begin
        if (mode_nxt != MODE_TEXT) begin
          err_nxt = ERR_END_IN_TAG;
          ev_nxt  = EV_ERR;
        end else if (top_nxt != '0) begin
          err_nxt = ERR_UNCLOSED;
          ev_nxt  = EV_ERR;
        end
      end

      if (ev_nxt == EV_ERR) begin
        err_lat_nxt = 1'b1;
        dep_nxt     = 5'(top_nxt);
        cout_nxt    = '0;
        run_nxt     = 1'b0;
      end
    end

    // last character: drop all parser state
    if (last) begin
      mode_nxt    = MODE_TEXT;
      closing_nxt = 1'b0;
      npos_nxt    = '0;
      mism_nxt    = 1'b0;
      err_lat_nxt = 1'b0;
      run_act_nxt = 1'b0;
      top_nxt     = '0;
    end
  end

  // Parser state and output register: advance on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      closing_r   <= 1'b0;
      npos_r      <= '0;
      mism_r      <= 1'b0;
      err_lat_r   <= 1'b0;
      run_act_r   <= 1'b0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        out_valid_r <= in_chan.valid;
      end
      if (in_fire) begin
        mode_r    <= mode_nxt;
        closing_r <= closing_nxt;
        npos_r    <= npos_nxt;
        mism_r    <= mism_nxt;
        err_lat_r <= err_lat_nxt;
        run_act_r <= run_act_nxt;
        top_r     <= top_nxt;
        ev_r      <= ev_nxt;
        dep_r     <= dep_nxt;
        cout_r    <= cout_nxt;
        run_r     <= run_nxt;
        err_r     <= err_nxt;
        done_r    <= last;
      end
    end
  end

  // Staging buffer: write the opening name character at its position
  always_ff @(posedge clk) begin
    if (in_fire && stage_we) begin
      stage_r[pos_idx] <= c;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.event_res     = ev_r;
  assign out_chan.depth         = dep_r;
  assign out_chan.char_out      = cout_r;
  assign out_chan.run_start     = run_r;
  assign out_chan.error_code    = err_r;
  assign out_chan.document_done = done_r;

endmodule
